>>> src/ssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Types and constants shared by the species set compare block.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int WORD_W  = 32;
    localparam int CNT_W   = 11;
    localparam int POP_W   = $clog2(WORD_W + 1);
    localparam int SHIFT_W = $clog2(WORD_W);

    localparam logic [CNT_W-1:0]  TALLY_MAX     = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  SPECIES_RESET = CNT_W'(1024);
    localparam logic [WORD_W-1:0] WORD_ONES     = {WORD_W{1'b1}};

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [POP_W-1:0]  pop_t;

    // one classified word pair, front to back
    typedef struct packed {
        word_t union_word;
        word_t common_word;
        word_t minus_word;
        word_t rest_word;
        word_t word_a;
        pop_t  pop_a;
        pop_t  pop_b;
        pop_t  pop_common;
        logic  any_common;
        logic  a_extra;
        logic  b_extra;
        logic  last;
    } ssc_item_t;

    function automatic pop_t popcount(input word_t w);
        pop_t n;
        n = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            n = n + pop_t'(w[i]);
        end
        return n;
    endfunction

endpackage

>>> src/species_set_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// species_set_compare
// Streams word pairs of two species sets and returns per-word set words plus
// counts, key and containment flags on the last word.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  config    cfg_we                cfg_data (total species, 11 bits)
//  input     in_valid / in_ready   word_a, word_b, last_word
//  output    out_valid / out_ready union_word .. agree
//
//  one transaction per cycle sustained while out_ready holds; an accepted pair
//  is classified into the queue, then accumulated into the output register
//  rst_n clears queue, tallies and flags; total species resets to 1024
//  output stall backs up the queue; input stalls only when the queue is full
// ----------------------------------------------------------------------------
module species_set_compare #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  ssc_pkg::cnt_t    cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  ssc_pkg::word_t   word_a,
    input  ssc_pkg::word_t   word_b,
    input  logic             last_word,
    output logic             out_valid,
    input  logic             out_ready,
    output ssc_pkg::word_t   union_word,
    output ssc_pkg::word_t   common_word,
    output ssc_pkg::word_t   minus_word,
    output ssc_pkg::word_t   rest_word,
    output logic             final_out,
    output ssc_pkg::cnt_t    count_a,
    output ssc_pkg::cnt_t    count_b,
    output ssc_pkg::cnt_t    count_common,
    output ssc_pkg::word_t   hash_a,
    output logic             a_holds_b,
    output logic             overlap,
    output logic             agree
);
    import ssc_pkg::*;

    ssc_item_t push_item;
    ssc_item_t head_item;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      head_valid;

    ssc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .word_a    (word_a),
        .word_b    (word_b),
        .last_word (last_word),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    ssc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    ssc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .union_word   (union_word),
        .common_word  (common_word),
        .minus_word   (minus_word),
        .rest_word    (rest_word),
        .final_out    (final_out),
        .count_a      (count_a),
        .count_b      (count_b),
        .count_common (count_common),
        .hash_a       (hash_a),
        .a_holds_b    (a_holds_b),
        .overlap      (overlap),
        .agree        (agree)
    );

endmodule

>>> src/ssc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_front
// Accepts word pairs, holds the species count register and classifies each
// pair into set words, popcounts and flags for the queue.
// ----------------------------------------------------------------------------
module ssc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  ssc_pkg::cnt_t     cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  ssc_pkg::word_t    word_a,
    input  ssc_pkg::word_t    word_b,
    input  logic              last_word,
    input  logic              q_full,
    output logic              q_push,
    output ssc_pkg::ssc_item_t q_item
);
    import ssc_pkg::*;

    cnt_t                species_reg;
    logic [SHIFT_W-1:0]  sel;
    word_t               last_mask;
    word_t               rest_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            species_reg <= SPECIES_RESET;
        end
        else if (cfg_we)
        begin
            species_reg <= cfg_data;
        end
    end

    // bits kept in the last word: 1 + ((species - 1) mod word width)
    assign sel       = species_reg[SHIFT_W-1:0] - SHIFT_W'(1);
    assign last_mask = WORD_ONES >> (SHIFT_W'(WORD_W - 1) - sel);
    assign rest_raw  = ~word_a & ~word_b;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.union_word  = word_a | word_b;
        q_item.common_word = word_a & word_b;
        q_item.minus_word  = word_a & ~word_b;
        q_item.rest_word   = last_word ? (rest_raw & last_mask) : rest_raw;
        q_item.word_a      = word_a;
        q_item.pop_a       = popcount(word_a);
        q_item.pop_b       = popcount(word_b);
        q_item.pop_common  = popcount(word_a & word_b);
        q_item.any_common  = |(word_a & word_b);
        q_item.a_extra     = |(word_a & ~word_b);
        q_item.b_extra     = |(word_b & ~word_a);
        q_item.last        = last_word;
    end

    ap_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    ap_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> species_reg == $past(cfg_data))
        else $error("species register missed a write");

    ap_rest_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_item.rest_word & q_item.union_word) == '0)
        else $error("rest word overlaps union");

endmodule

>>> src/ssc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_queue
// Short queue of classified word pairs between front and back.
// ----------------------------------------------------------------------------
module ssc_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ssc_pkg::ssc_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output ssc_pkg::ssc_item_t head_item
);
    import ssc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    ssc_item_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    assign full       = fill_reg == FILL_W'(DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    ap_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(DEPTH))
        else $error("queue fill out of range");

    ap_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    ap_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> fill_reg == $past(fill_reg) + FILL_W'(1))
        else $error("fill count did not grow on push");

endmodule

>>> src/ssc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_back
// Takes classified pairs from the queue, keeps the running tallies, key and
// flags, and holds each result in the output register.
// ----------------------------------------------------------------------------
module ssc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  ssc_pkg::ssc_item_t head_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output ssc_pkg::word_t     union_word,
    output ssc_pkg::word_t     common_word,
    output ssc_pkg::word_t     minus_word,
    output ssc_pkg::word_t     rest_word,
    output logic               final_out,
    output ssc_pkg::cnt_t      count_a,
    output ssc_pkg::cnt_t      count_b,
    output ssc_pkg::cnt_t      count_common,
    output ssc_pkg::word_t     hash_a,
    output logic               a_holds_b,
    output logic               overlap,
    output logic               agree
);
    import ssc_pkg::*;

    cnt_t  tally_a_reg, tally_a_next;
    cnt_t  tally_b_reg, tally_b_next;
    cnt_t  tally_c_reg, tally_c_next;
    word_t xor_reg, xor_next;
    logic  ov_reg, ov_next;
    logic  ae_reg, ae_next;
    logic  be_reg, be_next;
    logic  out_valid_reg;

    word_t union_reg, common_reg, minus_reg, rest_reg, hash_reg;
    cnt_t  cnt_a_reg, cnt_b_reg, cnt_c_reg;
    logic  final_reg, holds_reg, overlap_reg, agree_reg;

    function automatic cnt_t sat_add(input cnt_t t, input pop_t n);
        logic [CNT_W:0] s;
        s = {1'b0, t} + (CNT_W + 1)'(n);
        return s[CNT_W] ? TALLY_MAX : s[CNT_W-1:0];
    endfunction

    assign pop = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        tally_a_next = sat_add(tally_a_reg, head_item.pop_a);
        tally_b_next = sat_add(tally_b_reg, head_item.pop_b);
        tally_c_next = sat_add(tally_c_reg, head_item.pop_common);
        xor_next     = xor_reg ^ head_item.word_a;
        ov_next      = ov_reg | head_item.any_common;
        ae_next      = ae_reg | head_item.a_extra;
        be_next      = be_reg | head_item.b_extra;
    end

    // accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_a_reg <= '0;
            tally_b_reg <= '0;
            tally_c_reg <= '0;
            xor_reg     <= '0;
            ov_reg      <= 1'b0;
            ae_reg      <= 1'b0;
            be_reg      <= 1'b0;
        end
        else if (pop)
        begin
            if (head_item.last)
            begin
                tally_a_reg <= '0;
                tally_b_reg <= '0;
                tally_c_reg <= '0;
                xor_reg     <= '0;
                ov_reg      <= 1'b0;
                ae_reg      <= 1'b0;
                be_reg      <= 1'b0;
            end
            else
            begin
                tally_a_reg <= tally_a_next;
                tally_b_reg <= tally_b_next;
                tally_c_reg <= tally_c_next;
                xor_reg     <= xor_next;
                ov_reg      <= ov_next;
                ae_reg      <= ae_next;
                be_reg      <= be_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            union_reg   <= head_item.union_word;
            common_reg  <= head_item.common_word;
            minus_reg   <= head_item.minus_word;
            rest_reg    <= head_item.rest_word;
            final_reg   <= head_item.last;
            cnt_a_reg   <= head_item.last ? tally_a_next : '0;
            cnt_b_reg   <= head_item.last ? tally_b_next : '0;
            cnt_c_reg   <= head_item.last ? tally_c_next : '0;
            hash_reg    <= head_item.last ? xor_next : '0;
            holds_reg   <= head_item.last && !be_next;
            overlap_reg <= head_item.last && ov_next;
            agree_reg   <= head_item.last && (!ov_next || !(ae_next && be_next));
        end
    end

    assign out_valid    = out_valid_reg;
    assign union_word   = union_reg;
    assign common_word  = common_reg;
    assign minus_word   = minus_reg;
    assign rest_word    = rest_reg;
    assign final_out    = final_reg;
    assign count_a      = cnt_a_reg;
    assign count_b      = cnt_b_reg;
    assign count_common = cnt_c_reg;
    assign hash_a       = hash_reg;
    assign a_holds_b    = holds_reg;
    assign overlap      = overlap_reg;
    assign agree        = agree_reg;

    ap_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_item.last |=> tally_a_reg == '0 && xor_reg == '0 && !ov_reg)
        else $error("accumulators not cleared after last word");

    ap_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !final_out |-> count_a == '0 && hash_a == '0 && !agree)
        else $error("summary fields set on inner word");

    ap_common_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_out |-> count_common <= count_a && count_common <= count_b)
        else $error("common count exceeds a set count");

    ap_overlap_agree: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_out && !overlap |-> agree)
        else $error("disjoint sets not reported compatible");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream checker for species_set_compare: word pairs of two species sets are
// sent in sets of varied length and relation (nested, disjoint, equal, mixed),
// each transaction is predicted in a small class and every result word and
// summary field is compared in order, across several species-count settings.
// ----------------------------------------------------------------------------
module tb_top;

    import ssc_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 185;
    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        word_t union_w;
        word_t common_w;
        word_t minus_w;
        word_t rest_w;
        logic  fin;
        cnt_t  members_a;
        cnt_t  members_b;
        cnt_t  members_common;
        word_t key_a;
        logic  a_covers_b;
        logic  shares;
        logic  compatible;
    } set_words_t;

    typedef enum int {
        REL_FREE,
        REL_B_IN_A,
        REL_A_IN_B,
        REL_APART,
        REL_SAME,
        REL_FLIPPED,
        REL_MIXED
    } relation_t;

    class set_compare_checker;
        cnt_t       species;
        cnt_t       tally_a;
        cnt_t       tally_b;
        cnt_t       tally_common;
        word_t      key;
        bit         saw_common;
        bit         a_extra;
        bit         b_extra;
        set_words_t pending_words[$];
        int         errors;

        function new();
            species = SPECIES_RESET;
            errors  = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            tally_a      = '0;
            tally_b      = '0;
            tally_common = '0;
            key          = '0;
            saw_common   = 1'b0;
            a_extra      = 1'b0;
            b_extra      = 1'b0;
        endfunction

        function cnt_t add_members(cnt_t t, int n);
            int s;
            s = int'(t) + n;
            return (s > int'(TALLY_MAX)) ? TALLY_MAX : cnt_t'(s);
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void note_pair(word_t a, word_t b, bit is_last);
            set_words_t w;
            word_t      both;
            int         used;
            both         = a & b;
            tally_a      = add_members(tally_a, $countones(a));
            tally_b      = add_members(tally_b, $countones(b));
            tally_common = add_members(tally_common, $countones(both));
            key          = key ^ a;
            if (both != '0)
                saw_common = 1'b1;
            if ((a & ~b) != '0)
                a_extra = 1'b1;
            if ((b & ~a) != '0)
                b_extra = 1'b1;
            w          = '0;
            w.union_w  = a | b;
            w.common_w = both;
            w.minus_w  = a & ~b;
            w.rest_w   = ~a & ~b;
            if (is_last)
            begin
                // species count of zero wraps to a full last word
                used = 1 + (((int'(species) + 2047) & 2047) % WORD_W);
                if (used < WORD_W)
                    w.rest_w = w.rest_w & ((word_t'(1) << used) - word_t'(1));
                w.fin            = 1'b1;
                w.members_a      = tally_a;
                w.members_b      = tally_b;
                w.members_common = tally_common;
                w.key_a          = key;
                w.a_covers_b     = !b_extra;
                w.shares         = saw_common;
                w.compatible     = !saw_common || !(a_extra && b_extra);
                clear_sums();
            end
            pending_words.insert(pending_words.size(), w);
        endfunction

        function void same_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(set_words_t got);
            set_words_t want;
            if (pending_words.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t unexpected result: expected none actual union %h",
                             $time, got.union_w);
                return;
            end
            want = pending_words.pop_front();
            same_field("union_word", want.union_w, got.union_w);
            same_field("common_word", want.common_w, got.common_w);
            same_field("minus_word", want.minus_w, got.minus_w);
            same_field("rest_word", want.rest_w, got.rest_w);
            same_field("final_out", 32'(want.fin), 32'(got.fin));
            same_field("count_a", 32'(want.members_a), 32'(got.members_a));
            same_field("count_b", 32'(want.members_b), 32'(got.members_b));
            same_field("count_common", 32'(want.members_common), 32'(got.members_common));
            same_field("hash_a", want.key_a, got.key_a);
            same_field("a_holds_b", 32'(want.a_covers_b), 32'(got.a_covers_b));
            same_field("overlap", 32'(want.shares), 32'(got.shares));
            same_field("agree", 32'(want.compatible), 32'(got.compatible));
        endfunction
    endclass

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  cfg_we    = 1'b0;
    cnt_t  cfg_data  = '0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    word_t word_a    = '0;
    word_t word_b    = '0;
    logic  last_word = 1'b0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    word_t union_word;
    word_t common_word;
    word_t minus_word;
    word_t rest_word;
    logic  final_out;
    cnt_t  count_a;
    cnt_t  count_b;
    cnt_t  count_common;
    word_t hash_a;
    logic  a_holds_b;
    logic  overlap;
    logic  agree;

    set_compare_checker sb;
    int cycles     = 0;
    int burst_left = 0;
    int phase_sent = 0;
    bit valid_up   = 1'b0;
    int stall_mode = 0;
    int stall_left = 0;

    species_set_compare i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .word_a       (word_a),
        .word_b       (word_b),
        .last_word    (last_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .union_word   (union_word),
        .common_word  (common_word),
        .minus_word   (minus_word),
        .rest_word    (rest_word),
        .final_out    (final_out),
        .count_a      (count_a),
        .count_b      (count_b),
        .count_common (count_common),
        .hash_a       (hash_a),
        .a_holds_b    (a_holds_b),
        .overlap      (overlap),
        .agree        (agree)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: check accepted transactions, stall on a changing pattern
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({union_word, common_word, minus_word, rest_word, final_out,
                             count_a, count_b, count_common, hash_a, a_holds_b,
                             overlap, agree});
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (cycles % 4 == 0);
            default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic send_word(input word_t a, input word_t b, input bit is_last);
        in_valid  <= 1'b1;
        valid_up   = 1'b1;
        word_a    <= a;
        word_b    <= b;
        last_word <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_pair(a, b, is_last);
        phase_sent++;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            valid_up  = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 12);
        end
        else
            burst_left--;
    endtask

    task automatic wait_drained();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up  = 1'b0;
        end
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_species(input cnt_t v);
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we     <= 1'b0;
        sb.species  = v;
    endtask

    function automatic word_t pick_word(bit dense);
        if (dense)
            return ($urandom_range(0, 9) < 7) ? WORD_ONES : ~($urandom & $urandom & $urandom);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WORD_ONES;
            2:       return word_t'(1) << $urandom_range(0, WORD_W - 1);
            3:       return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic word_t partner_word(relation_t rel, word_t a, bit dense);
        case (rel)
            REL_B_IN_A:  return a & pick_word(dense);
            REL_A_IN_B:  return a | pick_word(dense);
            REL_APART:   return ~a & pick_word(dense);
            REL_SAME:    return a;
            REL_FLIPPED: return ~a;
            REL_MIXED:   return partner_word(relation_t'($urandom_range(0, 5)), a, dense);
            default:     return pick_word(dense);
        endcase
    endfunction

    task automatic send_random_set();
        int        len;
        int        roll;
        bit        dense;
        relation_t rel;
        word_t     a;
        roll  = $urandom_range(0, 99);
        dense = (roll >= 92);
        if (roll < 70)
            len = $urandom_range(1, 4);
        else if (roll < 92)
            len = $urandom_range(5, 33);
        else
            len = $urandom_range(64, 72);
        rel = relation_t'($urandom_range(0, 6));
        for (int i = 0; i < len; i++)
        begin
            a = pick_word(dense);
            send_word(a, partner_word(rel, a, dense), i == len - 1);
        end
    endtask

    initial
    begin
        int plan [PHASES];
        plan = '{1024, 1, 0, 1024, 2047, 33, 31, 32, -1, -1};
        sb   = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edge cases at the reset species count
        send_word('0, '0, 1'b1);
        send_word(WORD_ONES, WORD_ONES, 1'b1);
        send_word(WORD_ONES, '0, 1'b1);
        send_word('0, WORD_ONES, 1'b1);
        send_word(32'hffff_0000, 32'h0000_ffff, 1'b0);
        send_word(32'h8000_0000, 32'h0000_0001, 1'b1);
        send_word(32'hffff_0000, 32'h00ff_00ff, 1'b0);
        send_word(32'h0000_0001, 32'h0000_0002, 1'b1);
        send_word(32'h5555_5555, 32'haaaa_aaaa, 1'b1);
        send_word(WORD_ONES, 32'h1234_5678, 1'b0);
        send_word(32'h0f0f_0f0f, 32'h0101_0101, 1'b0);
        send_word(32'h8000_0001, 32'h8000_0000, 1'b1);
        send_word(32'h0000_0100, 32'h0000_0f00, 1'b1);
        send_word(32'hdead_beef, 32'hdead_beef, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p != 0)
            begin
                wait_drained();
                write_species((plan[p] < 0) ? cnt_t'($urandom_range(0, 2047))
                                            : cnt_t'(plan[p]));
            end
            phase_sent = 0;
            send_word('0, '0, 1'b1);
            send_word(WORD_ONES, '0, 1'b1);
            while (phase_sent < PHASE_ITEMS)
                send_random_set();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
